// ----- rtl/sed_pkg.sv -----
// String escape decoder: shared types, codes and character helpers.
// Used by every module of the block and by the port checker.
package sed_pkg;

	localparam int unsigned MAX_RESULTS = 4;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_RANGE = 2'd2;
	localparam logic [1:0] KIND_SURR  = 2'd3;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CH_UP_U   = 8'h55;
	localparam logic [7:0] CH_LOW_X  = 8'h78;
	localparam logic [7:0] CH_UP_X   = 8'h58;

	localparam logic [31:0] CP_MAX      = 32'h0010_FFFF;
	localparam logic [31:0] CP_SURR_LO  = 32'h0000_D800;
	localparam logic [31:0] CP_SURR_HI  = 32'h0000_DFFF;
	localparam logic [31:0] CP_1BYTE    = 32'h0000_007F;
	localparam logic [31:0] CP_2BYTE    = 32'h0000_07FF;
	localparam logic [31:0] CP_3BYTE    = 32'h0000_FFFF;

	typedef enum logic [5:0] {
		MODE_IDLE = 6'b000001,
		MODE_ESC  = 6'b000010,
		MODE_HEX  = 6'b000100,
		MODE_OCT  = 6'b001000,
		MODE_UNI  = 6'b010000,
		MODE_DROP = 6'b100000
	} mode_t;

	// All results caused by one input transaction, in order.
	typedef struct packed {
		logic [2:0]                   cnt;
		logic [MAX_RESULTS-1:0][7:0]  data_b;
		logic [MAX_RESULTS-1:0][1:0]  kind_b;
	} bundle_t;

	function automatic bundle_t put(bundle_t b, logic [7:0] d, logic [1:0] k);
		bundle_t r;
		r = b;
		r.data_b[b.cnt[1:0]] = d;
		r.kind_b[b.cnt[1:0]] = k;
		r.cnt = b.cnt + 3'd1;
		return r;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_nibble(logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, c[3:0]};
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic logic is_oct(logic [7:0] c);
		return c inside {[8'h30:8'h37]};
	endfunction

	// {hit, value}
	function automatic logic [8:0] simple_esc(logic [7:0] c);
		logic [8:0] r;
		r = '0;
		case (c)
			8'h61: r = {1'b1, 8'd7};
			8'h62: r = {1'b1, 8'd8};
			8'h66: r = {1'b1, 8'd12};
			8'h6E: r = {1'b1, 8'd10};
			8'h72: r = {1'b1, 8'd13};
			8'h74: r = {1'b1, 8'd9};
			8'h76: r = {1'b1, 8'd11};
			8'h5C, 8'h27, 8'h22, 8'h3F: r = {1'b1, c};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/string_escape_decoder_unit.sv -----
// String escape decoder top level: front end, bundle queue and output serializer.
// Depends on sed_pkg, sed_front, sed_fifo and sed_back.
//
// Usage:
//   Input stream carries one string body character per transaction in s_tdata;
//   s_tlast marks the end-of-string transaction (s_tdata ignored there).
//   Output stream carries one result per transaction: decoded byte in m_tdata,
//   result kind in m_tuser (data, string end, out of range, surrogate), and
//   m_tlast on the final result caused by one input transaction.
// Path: a transaction that yields results enters the queue when it is accepted,
//   and its first result is loaded into the output register once it is free.
// Throughput: one input transaction per cycle while each one yields at most one
//   result and m_tready is high; the output register moves one result per cycle
//   while m_tready is high, so a multi-byte UTF-8 sequence or an escape flush,
//   two to four results, leaves the output one result at a time. The queue of
//   QUEUE_DEPTH bundles absorbs these bursts; s_tready drops only when full.
// Reset: clears the escape state to plain-character mode and empties the queue.
// Stall: while m_tready is low the output holds; input keeps flowing until the
//   queue fills.
module string_escape_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	input  logic       s_tlast,   // body_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [1:0] m_tuser,   // [1:0] kind
	output logic       m_tlast    // last
);

	logic             push;
	logic             full;
	logic             pop;
	logic             not_empty;
	sed_pkg::bundle_t wr_bundle;
	sed_pkg::bundle_t head;

	assign s_tready = !full;

	sed_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.ch       (s_tdata),
		.body_end (s_tlast),
		.push     (push),
		.bundle   (wr_bundle)
	);

	sed_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_bundle (wr_bundle),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	sed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (not_empty),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// ----- rtl/sed_front.sv -----
// Front end: accepts characters, tracks escape state, builds result bundles.
// Depends on sed_pkg.
module sed_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        ch,
	input  logic              body_end,
	output logic              push,
	output sed_pkg::bundle_t  bundle
);

	sed_pkg::mode_t mode_q, nxt_mode;
	logic [31:0]    acc_q, nxt_acc;
	logic [3:0]     cnt_q, nxt_cnt;
	logic           long_q, nxt_long;

	logic [4:0]     hx;
	logic [8:0]     se;
	logic [7:0]     acc_hex;
	logic [8:0]     acc_oct;
	logic [31:0]    cp;
	logic [3:0]     cnt_inc;
	logic [3:0]     uni_len;
	sed_pkg::bundle_t b;

	always_comb begin
		hx       = sed_pkg::hex_nibble(ch);
		se       = sed_pkg::simple_esc(ch);
		acc_hex  = {acc_q[3:0], hx[3:0]};
		acc_oct  = {acc_q[5:0], ch[2:0]};
		cp       = {acc_q[27:0], (hx[4] ? hx[3:0] : 4'd0)};
		cnt_inc  = cnt_q + 4'd1;
		uni_len  = long_q ? 4'd8 : 4'd4;
		nxt_mode = mode_q;
		nxt_acc  = acc_q;
		nxt_cnt  = cnt_q;
		nxt_long = long_q;
		b        = '0;
		if (body_end) begin
			if (mode_q == sed_pkg::MODE_HEX || mode_q == sed_pkg::MODE_OCT) begin
				b = sed_pkg::put(b, acc_q[7:0], sed_pkg::KIND_DATA);
			end else if (mode_q == sed_pkg::MODE_ESC) begin
				b = sed_pkg::put(b, 8'd0, sed_pkg::KIND_DATA);
			end
			b = sed_pkg::put(b, 8'd0, sed_pkg::KIND_END);
			nxt_mode = sed_pkg::MODE_IDLE;
			nxt_acc  = '0;
			nxt_cnt  = '0;
			nxt_long = 1'b0;
		end else begin
			case (mode_q)
				sed_pkg::MODE_ESC: begin
					nxt_mode = sed_pkg::MODE_IDLE;
					nxt_acc  = '0;
					nxt_cnt  = '0;
					nxt_long = 1'b0;
					if (se[8]) begin
						b = sed_pkg::put(b, se[7:0], sed_pkg::KIND_DATA);
					end else if (ch == sed_pkg::CH_LOW_U || ch == sed_pkg::CH_UP_U) begin
						nxt_mode = sed_pkg::MODE_UNI;
						nxt_long = (ch == sed_pkg::CH_UP_U);
					end else if (ch == sed_pkg::CH_LOW_X || ch == sed_pkg::CH_UP_X) begin
						nxt_mode = sed_pkg::MODE_HEX;
					end else if (sed_pkg::is_oct(ch)) begin
						nxt_mode = sed_pkg::MODE_OCT;
						nxt_acc  = {29'd0, ch[2:0]};
						nxt_cnt  = 4'd1;
					end else begin
						b = sed_pkg::put(b, 8'd0, sed_pkg::KIND_DATA);
						b = sed_pkg::put(b, ch, sed_pkg::KIND_DATA);
					end
				end
				sed_pkg::MODE_HEX: begin
					if (hx[4] && cnt_inc < 4'd2) begin
						nxt_acc = {24'd0, acc_hex};
						nxt_cnt = cnt_inc;
					end else begin
						nxt_mode = sed_pkg::MODE_IDLE;
						nxt_acc  = '0;
						nxt_cnt  = '0;
						nxt_long = 1'b0;
						if (hx[4]) begin
							b = sed_pkg::put(b, acc_hex, sed_pkg::KIND_DATA);
						end else begin
							b = sed_pkg::put(b, acc_q[7:0], sed_pkg::KIND_DATA);
							if (ch == sed_pkg::CH_BSLASH) begin
								nxt_mode = sed_pkg::MODE_ESC;
							end else begin
								b = sed_pkg::put(b, ch, sed_pkg::KIND_DATA);
							end
						end
					end
				end
				sed_pkg::MODE_OCT: begin
					if (sed_pkg::is_oct(ch) && cnt_inc < 4'd3) begin
						nxt_acc = {23'd0, acc_oct};
						nxt_cnt = cnt_inc;
					end else begin
						nxt_mode = sed_pkg::MODE_IDLE;
						nxt_acc  = '0;
						nxt_cnt  = '0;
						nxt_long = 1'b0;
						if (sed_pkg::is_oct(ch)) begin
							b = sed_pkg::put(b, acc_oct[7:0], sed_pkg::KIND_DATA);
						end else begin
							b = sed_pkg::put(b, acc_q[7:0], sed_pkg::KIND_DATA);
							if (ch == sed_pkg::CH_BSLASH) begin
								nxt_mode = sed_pkg::MODE_ESC;
							end else begin
								b = sed_pkg::put(b, ch, sed_pkg::KIND_DATA);
							end
						end
					end
				end
				sed_pkg::MODE_UNI: begin
					nxt_acc = cp;
					nxt_cnt = cnt_inc;
					if (cnt_inc >= uni_len) begin
						if (cp > sed_pkg::CP_MAX) begin
							nxt_mode = sed_pkg::MODE_DROP;
							b = sed_pkg::put(b, 8'd0, sed_pkg::KIND_RANGE);
						end else if (cp >= sed_pkg::CP_SURR_LO && cp <= sed_pkg::CP_SURR_HI) begin
							nxt_mode = sed_pkg::MODE_DROP;
							b = sed_pkg::put(b, 8'd0, sed_pkg::KIND_SURR);
						end else begin
							nxt_mode = sed_pkg::MODE_IDLE;
							nxt_acc  = '0;
							nxt_cnt  = '0;
							nxt_long = 1'b0;
							if (cp <= sed_pkg::CP_1BYTE) begin
								b = sed_pkg::put(b, cp[7:0], sed_pkg::KIND_DATA);
							end else if (cp <= sed_pkg::CP_2BYTE) begin
								b = sed_pkg::put(b, {3'b110, cp[10:6]}, sed_pkg::KIND_DATA);
								b = sed_pkg::put(b, {2'b10, cp[5:0]}, sed_pkg::KIND_DATA);
							end else if (cp <= sed_pkg::CP_3BYTE) begin
								b = sed_pkg::put(b, {4'b1110, cp[15:12]}, sed_pkg::KIND_DATA);
								b = sed_pkg::put(b, {2'b10, cp[11:6]}, sed_pkg::KIND_DATA);
								b = sed_pkg::put(b, {2'b10, cp[5:0]}, sed_pkg::KIND_DATA);
							end else begin
								b = sed_pkg::put(b, {5'b11110, cp[20:18]}, sed_pkg::KIND_DATA);
								b = sed_pkg::put(b, {2'b10, cp[17:12]}, sed_pkg::KIND_DATA);
								b = sed_pkg::put(b, {2'b10, cp[11:6]}, sed_pkg::KIND_DATA);
								b = sed_pkg::put(b, {2'b10, cp[5:0]}, sed_pkg::KIND_DATA);
							end
						end
					end
				end
				sed_pkg::MODE_DROP: begin
					nxt_mode = sed_pkg::MODE_DROP;
				end
				default: begin
					nxt_mode = sed_pkg::MODE_IDLE;
					nxt_acc  = '0;
					nxt_cnt  = '0;
					nxt_long = 1'b0;
					if (ch == sed_pkg::CH_BSLASH) begin
						nxt_mode = sed_pkg::MODE_ESC;
					end else begin
						b = sed_pkg::put(b, ch, sed_pkg::KIND_DATA);
					end
				end
			endcase
		end
	end

	assign bundle = b;
	assign push   = in_valid && in_ready && (b.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sed_pkg::MODE_IDLE;
			acc_q  <= '0;
			cnt_q  <= '0;
			long_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			mode_q <= nxt_mode;
			acc_q  <= nxt_acc;
			cnt_q  <= nxt_cnt;
			long_q <= nxt_long;
		end
	end

endmodule

// ----- rtl/sed_fifo.sv -----
// Bundle queue between the front end and the output serializer.
// Depends on sed_pkg.
module sed_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sed_pkg::bundle_t  wr_bundle,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output sed_pkg::bundle_t  head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sed_pkg::bundle_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/sed_back.sv -----
// Output serializer: walks the head bundle into a register one result per cycle,
// while the output is not stalled. Depends on sed_pkg.
module sed_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  sed_pkg::bundle_t  head,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	logic       load;
	logic       is_last;
	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] data_q;
	logic [1:0] user_q;
	logic       last_q;

	assign load    = !valid_q || m_tready;
	assign is_last = (({1'b0, idx_q} + 3'd1) == head.cnt);
	assign pop     = load && head_valid && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			data_q <= head.data_b[idx_q];
			user_q <= head.kind_b[idx_q];
			last_q <= is_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

endmodule

// ----- rtl/sed_checker.sv -----
// Port checker for the string escape decoder, bound to the top level.
// Depends on sed_pkg.
module sed_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       m_tlast
);

	// Hold a stalled input transaction.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
		else $error("input changed while stalled");

	// Hold a stalled output transaction.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output changed while stalled");

	a_nondata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != sed_pkg::KIND_DATA |-> m_tdata == 8'd0)
		else $error("non-data result carries a byte");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == sed_pkg::KIND_END |-> m_tlast)
		else $error("string end is not the final result");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == sed_pkg::KIND_RANGE || m_tuser == sed_pkg::KIND_SURR)
			|-> m_tlast)
		else $error("error result is not alone");

endmodule

bind string_escape_decoder_unit sed_checker u_sed_checker (.*);

// ----- tb/string_escape_decoder_unit_checker.sv -----
`timescale 1ns / 1ps
// Result checker for string_escape_decoder_unit: follows both stream ports, decodes each
// accepted character with its own escape decoder and compares every result in order.
// Depends on sed_pkg for result kinds, decoder modes, character codes and code point limits.
module string_escape_decoder_unit_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	input  logic       s_tlast,   // body_end
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_byte
	input  logic [1:0] m_tuser,   // [1:0] kind
	input  logic       m_tlast,   // last
	output int         fail_count,
	output int         pending,
	output int         chars_seen,
	output int         results_seen,
	output int         strings_seen,
	output int         cp_errors_seen
);

	typedef struct packed {
		logic [7:0] value;
		logic [1:0] kind;
		logic       last;
	} result_t;

	sed_pkg::mode_t dec_mode;
	logic [31:0]    dec_accum;
	logic [3:0]     dec_digits;
	logic           dec_long;

	result_t decoded_q[$];
	result_t awaited_q[$];
	result_t want;
	result_t got;

	function automatic int nibble_val(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	function automatic logic [8:0] simple_value(input logic [7:0] c);
		case (c)
			"a": return {1'b1, 8'd7};
			"b": return {1'b1, 8'd8};
			"f": return {1'b1, 8'd12};
			"n": return {1'b1, 8'd10};
			"r": return {1'b1, 8'd13};
			"t": return {1'b1, 8'd9};
			"v": return {1'b1, 8'd11};
			"\\", "'", "\"", "?": return {1'b1, c};
			default: return 9'd0;
		endcase
	endfunction

	task automatic add(input logic [7:0] v, input logic [1:0] k);
		result_t r;
		r = '{value: v, kind: k, last: 1'b0};
		decoded_q = {decoded_q, r};
	endtask

	task automatic go_idle();
		dec_mode = sed_pkg::MODE_IDLE;
		dec_accum = '0;
		dec_digits = '0;
		dec_long = 1'b0;
	endtask

	task automatic fresh(input logic [7:0] c);
		if (c == sed_pkg::CH_BSLASH) begin
			go_idle();
			dec_mode = sed_pkg::MODE_ESC;
		end else begin
			add(c, sed_pkg::KIND_DATA);
		end
	endtask

	task automatic encode_cp(input logic [31:0] cp);
		if (cp > sed_pkg::CP_MAX) begin
			dec_mode = sed_pkg::MODE_DROP;
			add(8'h00, sed_pkg::KIND_RANGE);
		end else if (cp >= sed_pkg::CP_SURR_LO && cp <= sed_pkg::CP_SURR_HI) begin
			dec_mode = sed_pkg::MODE_DROP;
			add(8'h00, sed_pkg::KIND_SURR);
		end else begin
			go_idle();
			if (cp <= sed_pkg::CP_1BYTE) begin
				add(cp[7:0], sed_pkg::KIND_DATA);
			end else if (cp <= sed_pkg::CP_2BYTE) begin
				add(8'hC0 | {3'b0, cp[10:6]}, sed_pkg::KIND_DATA);
				add(8'h80 | {2'b0, cp[5:0]}, sed_pkg::KIND_DATA);
			end else if (cp <= sed_pkg::CP_3BYTE) begin
				add(8'hE0 | {4'b0, cp[15:12]}, sed_pkg::KIND_DATA);
				add(8'h80 | {2'b0, cp[11:6]}, sed_pkg::KIND_DATA);
				add(8'h80 | {2'b0, cp[5:0]}, sed_pkg::KIND_DATA);
			end else begin
				add(8'hF0 | {5'b0, cp[20:18]}, sed_pkg::KIND_DATA);
				add(8'h80 | {2'b0, cp[17:12]}, sed_pkg::KIND_DATA);
				add(8'h80 | {2'b0, cp[11:6]}, sed_pkg::KIND_DATA);
				add(8'h80 | {2'b0, cp[5:0]}, sed_pkg::KIND_DATA);
			end
		end
	endtask

	task automatic escape_char(input logic [7:0] c);
		logic [8:0] simple;
		simple = simple_value(c);
		go_idle();
		if (simple[8]) begin
			add(simple[7:0], sed_pkg::KIND_DATA);
		end else if (c == sed_pkg::CH_LOW_U || c == sed_pkg::CH_UP_U) begin
			dec_mode = sed_pkg::MODE_UNI;
			dec_long = (c == sed_pkg::CH_UP_U);
		end else if (c == sed_pkg::CH_LOW_X || c == sed_pkg::CH_UP_X) begin
			dec_mode = sed_pkg::MODE_HEX;
		end else if (c >= "0" && c <= "7") begin
			dec_mode = sed_pkg::MODE_OCT;
			dec_accum = 32'(c - "0");
			dec_digits = 4'd1;
		end else begin
			add(8'h00, sed_pkg::KIND_DATA);
			fresh(c);
		end
	endtask

	task automatic decode(input logic [7:0] c, input logic fin);
		int d;
		decoded_q.delete();
		if (fin) begin
			if (dec_mode == sed_pkg::MODE_HEX || dec_mode == sed_pkg::MODE_OCT) begin
				add(dec_accum[7:0], sed_pkg::KIND_DATA);
			end else if (dec_mode == sed_pkg::MODE_ESC) begin
				add(8'h00, sed_pkg::KIND_DATA);
			end
			add(8'h00, sed_pkg::KIND_END);
			go_idle();
		end else begin
			case (dec_mode)
				sed_pkg::MODE_ESC: escape_char(c);
				sed_pkg::MODE_HEX: begin
					d = nibble_val(c);
					if (d >= 0) begin
						dec_accum = ((dec_accum << 4) | 32'(d)) & 32'hFF;
						dec_digits = dec_digits + 4'd1;
						if (dec_digits >= 4'd2) begin
							add(dec_accum[7:0], sed_pkg::KIND_DATA);
							go_idle();
						end
					end else begin
						add(dec_accum[7:0], sed_pkg::KIND_DATA);
						go_idle();
						fresh(c);
					end
				end
				sed_pkg::MODE_OCT: begin
					if (c >= "0" && c <= "7") begin
						dec_accum = ((dec_accum << 3) | 32'(c - "0")) & 32'h1FF;
						dec_digits = dec_digits + 4'd1;
						if (dec_digits >= 4'd3) begin
							add(dec_accum[7:0], sed_pkg::KIND_DATA);
							go_idle();
						end
					end else begin
						add(dec_accum[7:0], sed_pkg::KIND_DATA);
						go_idle();
						fresh(c);
					end
				end
				sed_pkg::MODE_UNI: begin
					d = nibble_val(c);
					if (d < 0) d = 0;
					dec_accum = (dec_accum << 4) | 32'(d);
					dec_digits = dec_digits + 4'd1;
					if (dec_digits >= (dec_long ? 4'd8 : 4'd4)) encode_cp(dec_accum);
				end
				sed_pkg::MODE_DROP: ;
				default: begin
					go_idle();
					fresh(c);
				end
			endcase
		end
		for (int i = 0; i < decoded_q.size(); i++) begin
			want = decoded_q[i];
			want.last = (i == decoded_q.size() - 1);
			awaited_q = {awaited_q, want};
		end
	endtask

	task automatic note_mismatch(input string what, input result_t exp_r, input result_t act_r);
		fail_count++;
		if (fail_count <= 10) begin
			$display("[%0t] %s: expected byte %02h kind %0d last %0b, got byte %02h kind %0d last %0b",
				$time, what, exp_r.value, exp_r.kind, exp_r.last,
				act_r.value, act_r.kind, act_r.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_idle();
			awaited_q.delete();
			fail_count = 0;
			pending = 0;
			chars_seen = 0;
			results_seen = 0;
			strings_seen = 0;
			cp_errors_seen = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode(s_tdata, s_tlast);
				chars_seen++;
			end
			if (m_tvalid && m_tready) begin
				got = '{value: m_tdata, kind: m_tuser, last: m_tlast};
				results_seen++;
				if (awaited_q.size() == 0) begin
					note_mismatch("result with nothing pending", '0, got);
				end else begin
					want = awaited_q.pop_front();
					if (got !== want) note_mismatch("result mismatch", want, got);
					if (want.kind == sed_pkg::KIND_END) strings_seen++;
					if (want.kind == sed_pkg::KIND_RANGE || want.kind == sed_pkg::KIND_SURR) begin
						cp_errors_seen++;
					end
				end
			end
			pending = awaited_q.size();
		end
	end

endmodule

// ----- tb/string_escape_decoder_unit_tb.sv -----
`timescale 1ns / 1ps
// Top of the string_escape_decoder_unit regression: clock, reset, character stimulus and
// output stalls; the verdict comes from string_escape_decoder_unit_checker and sed_pkg.
module string_escape_decoder_unit_tb;

	localparam int DIRECTED_ITEMS = 29;
	localparam int RANDOM_ITEMS   = 280;
	localparam int HOLD_CYCLES    = 150;
	localparam int SETTLE_CYCLES  = 8;
	localparam int CYCLE_LIMIT    = 200000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] ch
	logic       s_tlast = 1'b0;    // body_end
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] out_byte
	logic [1:0] m_tuser;           // [1:0] kind
	logic       m_tlast;           // last

	int fail_count;
	int pending;
	int chars_seen;
	int results_seen;
	int strings_seen;
	int cp_errors_seen;

	int sent = 0;
	int burst_left = 0;
	int hold_req = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int stall_style = 0;
	int style_left = 0;
	int rx_tick = 0;
	int cycle_count = 0;
	bit hold_asked = 1'b0;
	bit drained = 1'b0;
	string simple_set = "abfnrtv\\'\"?";

	string_escape_decoder_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	string_escape_decoder_unit_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.fail_count     (fail_count),
		.pending        (pending),
		.chars_seen     (chars_seen),
		.results_seen   (results_seen),
		.strings_seen   (strings_seen),
		.cp_errors_seen (cp_errors_seen)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("string_escape_decoder_unit regression: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		rx_tick <= rx_tick + 1;
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_taken != hold_req) begin
			hold_taken <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				stall_style <= $urandom_range(0, 3);
				style_left <= $urandom_range(20, 120);
			end else begin
				style_left <= style_left - 1;
			end
			case (stall_style)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) == 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (rx_tick % 5 != 2);
			endcase
		end
	end

	task automatic send(input logic [7:0] c, input logic fin);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		burst_left--;
		s_tvalid = 1'b1;
		s_tdata = c;
		s_tlast = fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
	endtask

	task automatic send_end();
		send(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// most significant nibble first; now and then a character that is not a hex digit
	task automatic send_digits(input logic [31:0] val, input int n);
		logic [3:0] nib;
		for (int i = n - 1; i >= 0; i--) begin
			nib = val[4*i +: 4];
			if ($urandom_range(0, 39) == 0) begin
				send($urandom_range(0, 1) ? "g" : "Z", 1'b0);
			end else if (nib < 4'd10) begin
				send("0" + 8'(nib), 1'b0);
			end else begin
				send(($urandom_range(0, 1) ? "a" : "A") + 8'(nib - 4'd10), 1'b0);
			end
		end
	endtask

	function automatic logic [31:0] pick_cp();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, sed_pkg::CP_1BYTE);
			1: return $urandom_range(sed_pkg::CP_1BYTE + 1, sed_pkg::CP_2BYTE);
			2: return $urandom_range(sed_pkg::CP_2BYTE + 1, sed_pkg::CP_3BYTE);
			3: return $urandom_range(sed_pkg::CP_SURR_LO, sed_pkg::CP_SURR_HI);
			4: begin
				case ($urandom_range(0, 8))
					0: return sed_pkg::CP_1BYTE;
					1: return sed_pkg::CP_1BYTE + 1;
					2: return sed_pkg::CP_2BYTE;
					3: return sed_pkg::CP_2BYTE + 1;
					4: return sed_pkg::CP_SURR_LO - 1;
					5: return sed_pkg::CP_SURR_HI + 1;
					6: return sed_pkg::CP_3BYTE;
					7: return sed_pkg::CP_MAX;
					default: return sed_pkg::CP_MAX + 1;
				endcase
			end
			5: return $urandom_range(sed_pkg::CP_3BYTE + 1, sed_pkg::CP_MAX);
			6: return $urandom_range(sed_pkg::CP_MAX + 1, 32'hFFFF_FFFF);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_token();
		logic [7:0] c;
		case ($urandom_range(0, 11))
			0, 1, 2, 3: begin
				do c = 8'($urandom_range(0, 255)); while (c == sed_pkg::CH_BSLASH);
				send(c, 1'b0);
			end
			4: begin
				send(sed_pkg::CH_BSLASH, 1'b0);
				send(simple_set[$urandom_range(0, simple_set.len() - 1)], 1'b0);
			end
			5: begin
				send(sed_pkg::CH_BSLASH, 1'b0);
				send($urandom_range(0, 1) ? sed_pkg::CH_LOW_X : sed_pkg::CH_UP_X, 1'b0);
				send_digits($urandom, $urandom_range(1, 2));
			end
			6: begin
				send(sed_pkg::CH_BSLASH, 1'b0);
				repeat ($urandom_range(1, 3)) send("0" + 8'($urandom_range(0, 7)), 1'b0);
			end
			7, 8: begin
				send(sed_pkg::CH_BSLASH, 1'b0);
				send(sed_pkg::CH_LOW_U, 1'b0);
				send_digits(pick_cp(), 4);
			end
			9, 10: begin
				send(sed_pkg::CH_BSLASH, 1'b0);
				send(sed_pkg::CH_UP_U, 1'b0);
				send_digits(pick_cp(), 8);
			end
			default: begin
				send(sed_pkg::CH_BSLASH, 1'b0);
				send(8'($urandom_range(0, 255)), 1'b0);
			end
		endcase
	endtask

	task automatic random_string();
		repeat ($urandom_range(1, 10)) begin
			if ($urandom_range(0, 9) == 0) send(8'($urandom_range(0, 255)), 1'b0);
			else random_token();
		end
		case ($urandom_range(0, 9))
			0: send(sed_pkg::CH_BSLASH, 1'b0);
			1: begin
				send(sed_pkg::CH_BSLASH, 1'b0);
				send(sed_pkg::CH_LOW_X, 1'b0);
				send_digits($urandom, 1);
			end
			2: begin
				send(sed_pkg::CH_BSLASH, 1'b0);
				send("0" + 8'($urandom_range(0, 7)), 1'b0);
			end
			3: begin
				send(sed_pkg::CH_BSLASH, 1'b0);
				send(sed_pkg::CH_LOW_U, 1'b0);
				send_digits($urandom, $urandom_range(1, 3));
			end
			default: ;
		endcase
		send_end();
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(8'h00, 1'b0);
		send(8'hFF, 1'b0);
		send_text("\\n\\xFf\\777\\xz\\q");
		send_end();
		send_text("\\uD800ab");
		send_end();
		send_text("\\");
		send_end();

		while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			if (!hold_asked && sent >= 120) begin
				hold_req <= hold_req + 1;
				hold_asked = 1'b1;
			end
			if (!drained && sent >= 220) begin
				drain();
				drained = 1'b1;
			end
			random_string();
		end
		drain();

		$display("covered %0d characters and end markers in %0d strings, %0d results checked",
			chars_seen, strings_seen, results_seen);
		$display("%0d code point errors decoded, %0d mismatches", cp_errors_seen, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("string_escape_decoder_unit regression: pass");
		end else begin
			$display("string_escape_decoder_unit regression: fail");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/sed_pkg.sv
rtl/sed_front.sv
rtl/sed_fifo.sv
rtl/sed_back.sv
rtl/string_escape_decoder_unit.sv
rtl/sed_checker.sv
tb/string_escape_decoder_unit_checker.sv
tb/string_escape_decoder_unit_tb.sv
